// ===== rtl/core/dsi_pkg.sv =====
package dsi_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ValW  = 64;

  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_ONE   = 8'h31;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  // 2^63 and floor(2^63 / 10)
  localparam logic [ValW-1:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [ValW-1:0] MAG_TENTH = 64'd922337203685477580;

  // parser phase codes
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  typedef struct packed {
    logic [ValW-1:0] mag;
    logic            neg;
    logic [1:0]      phase;
    logic            failed;
  } dsi_state_t;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   ok;
  } dsi_res_t;

endpackage

// ===== rtl/core/dsi_char_if.sv =====
interface dsi_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/core/dsi_res_if.sv =====
interface dsi_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] parsed_value;
  logic               parse_ok;

  modport source (output valid, output parsed_value, output parse_ok, input ready);
  modport sink (input valid, input parsed_value, input parse_ok, output ready);
endinterface

// ===== rtl/core/dsi_step.sv =====
module dsi_step (
  input  dsi_pkg::dsi_state_t cur_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output dsi_pkg::dsi_state_t nxt_o,
  output dsi_pkg::dsi_res_t   res_o
);
  import dsi_pkg::*;

  logic            is_digit;
  logic [3:0]      digit;
  logic [ValW-1:0] prod;
  logic            take_first;
  logic            ok;

  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign digit    = 4'(char_i - CHAR_ZERO);
  // times ten plus digit; only used while mag <= MAG_TENTH, so no wrap
  assign prod     = (cur_i.mag << 3) + (cur_i.mag << 1) + {{(ValW-4){1'b0}}, digit};

  always_comb begin
    nxt_o      = cur_i;
    take_first = 1'b0;
    if (!cur_i.failed) begin
      unique case (cur_i.phase)
        PH_SIGN: begin
          take_first = 1'b1;
        end
        PH_DIGITS: begin
          if (!is_digit || (cur_i.mag > MAG_TENTH) || (prod > MAG_LIMIT)) begin
            nxt_o.failed = 1'b1;
          end else begin
            nxt_o.mag = prod;
          end
        end
        default: begin
          // start phase; the unused code behaves the same
          if (char_i == CHAR_MINUS) begin
            nxt_o.neg   = 1'b1;
            nxt_o.phase = PH_SIGN;
            if (last_i) nxt_o.failed = 1'b1;
          end else begin
            take_first = 1'b1;
          end
        end
      endcase
    end
    if (take_first) begin
      nxt_o.phase = PH_DIGITS;
      if ((char_i >= CHAR_ONE) && (char_i <= CHAR_NINE)) begin
        nxt_o.mag = {{(ValW-4){1'b0}}, digit};
      end else if (char_i == CHAR_ZERO) begin
        nxt_o.mag = '0;
        // leading zero only allowed alone
        if (!last_i) nxt_o.failed = 1'b1;
      end else begin
        nxt_o.failed = 1'b1;
      end
    end
  end

  always_comb begin
    ok = !nxt_o.failed && (nxt_o.phase == PH_DIGITS);
    if (ok && !nxt_o.neg && (nxt_o.mag > (MAG_LIMIT - 64'd1))) ok = 1'b0;
    res_o.ok = ok;
    if (!ok) begin
      res_o.value = '0;
    end else if (nxt_o.neg) begin
      res_o.value = $signed(64'd0 - nxt_o.mag);
    end else begin
      res_o.value = $signed(nxt_o.mag);
    end
  end

endmodule

// ===== rtl/core/decimal_string_to_int64.sv =====
// Path: each character is captured in the input register, and a string's result in the result register.
// Throughput: one character per cycle, sustained while the result side does not stall; a
// result that waits for ready holds back the next character in the input register.
// The per-character multiply-by-ten and add completes in the single step between registers.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to the start.
module decimal_string_to_int64 (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsi_char_if.sink  req_i,
  dsi_res_if.source res_o
);
  import dsi_pkg::*;

  logic                s1_valid_q;
  logic [CharW-1:0]    s1_char_q;
  logic                s1_last_q;
  logic                s1_adv;

  dsi_state_t          state_q;
  dsi_state_t          state_d;
  dsi_res_t            step_res;

  logic                out_valid_q;
  logic signed [ValW-1:0] out_value_q;
  logic                out_ok_q;

  assign s1_adv    = s1_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;

  dsi_step u_step (
    .cur_i  (state_q),
    .char_i (s1_char_q),
    .last_i (s1_last_q),
    .nxt_o  (state_d),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (req_i.ready) s1_valid_q <= req_i.valid;
      if (s1_adv) begin
        // drop all state at the end of a string
        state_q <= s1_last_q ? dsi_state_t'('0) : state_d;
      end
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_char_q <= req_i.char_code;
      s1_last_q <= req_i.last_char;
    end
    if (s1_adv && s1_last_q) begin
      out_value_q <= step_res.value;
      out_ok_q    <= step_res.ok;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.parsed_value = out_value_q;
  assign res_o.parse_ok     = out_ok_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_value_q == '0))
    else $error("failed parse carries nonzero value");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (state_q == dsi_state_t'('0)))
    else $error("parser state not cleared after string end");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_char_q) && $stable(s1_last_q)))
    else $error("stalled character lost");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_UNUSED))
    else $error("unused parser phase entered");

endmodule

// ===== sim/tb_decimal_string_to_int64.sv =====
`timescale 1ns / 1ps

module tb_decimal_string_to_int64;
  import dsi_pkg::*;

  localparam int unsigned MaxCycles   = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseChars  = 550;

  class int64_parse_scoreboard;
    logic [ValW-1:0] mag;
    logic            neg;
    logic [1:0]      phase;
    logic            failed;
    dsi_res_t        expected_q[$];
    int unsigned     mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      mag    = '0;
      neg    = 1'b0;
      phase  = PH_START;
      failed = 1'b0;
    endfunction

    function void take_first_digit(logic [CharW-1:0] c, logic is_last);
      if (c >= CHAR_ONE && c <= CHAR_NINE) begin
        mag = ValW'(c - CHAR_ZERO);
      end else if (c == CHAR_ZERO) begin
        mag = '0;
        if (!is_last) failed = 1'b1;
      end else begin
        failed = 1'b1;
      end
      phase = PH_DIGITS;
    endfunction

    // Advance the parser by one accepted character; queue a result on the final one.
    function void note_char(logic [CharW-1:0] c, logic is_last);
      logic [ValW-1:0] nxt;
      dsi_res_t        res;
      if (!failed) begin
        case (phase)
          PH_SIGN: begin
            take_first_digit(c, is_last);
          end
          PH_DIGITS: begin
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
              failed = 1'b1;
            end else if (mag > MAG_TENTH) begin
              failed = 1'b1;
            end else begin
              nxt = mag * 64'd10 + ValW'(c - CHAR_ZERO);
              if (nxt > MAG_LIMIT) failed = 1'b1;
              else mag = nxt;
            end
          end
          default: begin
            if (c == CHAR_MINUS) begin
              neg   = 1'b1;
              phase = PH_SIGN;
              if (is_last) failed = 1'b1;
            end else begin
              take_first_digit(c, is_last);
            end
          end
        endcase
      end
      if (!is_last) return;
      res.ok    = !failed && phase == PH_DIGITS;
      res.value = '0;
      if (res.ok) begin
        if (neg) res.value = '0 - mag;
        else if (mag > MAG_LIMIT - 1) res.ok = 1'b0;
        else res.value = mag;
      end
      expected_q.push_back(res);
      clear();
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic signed [ValW-1:0] value, logic ok);
      dsi_res_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value=%0d ok=%0b", value, ok));
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value)
        report($sformatf("parsed_value got %0d want %0d", value, exp_res.value));
      if (ok !== exp_res.ok)
        report($sformatf("parse_ok got %0b want %0b", ok, exp_res.ok));
    endtask
  endclass

  logic clk;
  logic rst_n;

  dsi_char_if req_if ();
  dsi_res_if  res_if ();

  decimal_string_to_int64 uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  int64_parse_scoreboard sb = new();

  int unsigned     src_idle_pct;
  int unsigned     snk_idle_pct;
  int unsigned     chars_sent;
  int unsigned     cycle_cnt;
  logic [CharW-1:0] str_q[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      sb.check_result(res_if.parsed_value, res_if.parse_ok);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < MaxCycles) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Hold the request until the block takes it, then note it.
  task automatic send_char(input logic [CharW-1:0] c, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.char_code <= c;
    req_if.last_char <= is_last;
    do @(posedge clk); while (!req_if.ready);
    sb.note_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_queue();
    foreach (str_q[i]) send_char(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    send_queue();
  endtask

  initial begin
    int unsigned      src_pct[3];
    int unsigned      snk_pct[3];
    int unsigned      kind;
    int unsigned      len;
    int unsigned      pos;
    logic             neg;
    logic [ValW:0]    n;

    src_pct = '{21, 88, 0};
    snk_pct = '{88, 21, 0};
    src_idle_pct = src_pct[0];
    snk_idle_pct = snk_pct[0];
    chars_sent = 0;
    rst_n = 1'b0;
    req_if.valid     = 1'b0;
    req_if.char_code = '0;
    req_if.last_char = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // lone zeros, lone minus, leading zero, misplaced minus, non-digits
    send_text("0");
    send_text("-0");
    send_text("-");
    send_text("07");
    send_text("1-");
    send_text("-a");
    send_text("-9");
    send_text("42");
    send_text("3:");
    send_text("/");
    str_q = '{8'hFF};
    send_queue();
    str_q = '{8'h00};
    send_queue();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = src_pct[ph];
      snk_idle_pct = snk_pct[ph];
      chars_sent = 0;
      while (chars_sent < PhaseChars) begin
        kind = $urandom_range(99);
        neg  = 1'($urandom_range(1));
        str_q.delete();
        if (kind < 20) begin
          // values around the signed 64-bit limits and beyond, plus small values up to 1000
          case ($urandom_range(2))
            0: n = {1'b0, MAG_LIMIT} + (ValW+1)'($urandom_range(8)) - (ValW+1)'(4);
            1: begin
              n = {1'b0, $urandom, $urandom};
              n[ValW-1] = 1'b1;
              n[ValW] = 1'($urandom_range(1));
            end
            default: n = (ValW+1)'($urandom_range(1000));
          endcase
          do begin
            str_q.push_front(CHAR_ZERO + CharW'(n % 65'd10));
            n = n / 65'd10;
          end while (n != 0);
          if (neg) str_q.push_front(CHAR_MINUS);
        end else if (kind < 80) begin
          if (neg) str_q.push_back(CHAR_MINUS);
          if ($urandom_range(15) == 0) begin
            str_q.push_back(CHAR_ZERO);
          end else begin
            len = (kind < 40) ? $urandom_range(1, 19) : $urandom_range(1, 6);
            str_q.push_back(CHAR_ONE + CharW'($urandom_range(8)));
            for (int i = 1; i < len; i++) str_q.push_back(CHAR_ZERO + CharW'($urandom_range(9)));
          end
          // break some of the well-formed strings
          if (kind >= 62) begin
            case ($urandom_range(3))
              0: str_q[$urandom_range(str_q.size() - 1)] = CharW'($urandom_range(255));
              1: begin
                if (str_q.size() > 1) begin
                  pos = $urandom_range(1, str_q.size() - 1);
                  str_q.insert(pos, CHAR_MINUS);
                end else begin
                  str_q.push_back(CHAR_MINUS);
                end
              end
              2: str_q.insert((str_q[0] == CHAR_MINUS) ? 1 : 0, CHAR_ZERO);
              default: str_q = '{CHAR_MINUS};
            endcase
          end
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) str_q.push_back(CharW'($urandom_range(255)));
        end
        send_queue();
      end
    end

    req_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
